// ----- rtl/can_fs_pkg.sv -----
// shared types, constants and helpers for the can frame stuffing block
package can_fs_pkg;

   localparam int FrameBits    = 39;
   localparam int StdBits      = 19;
   localparam int ByteBits     = 8;
   localparam int MaxBytes     = 8;
   localparam int CountWidth   = $clog2(FrameBits + 1);
   localparam int CrcWidth     = 15;
   localparam int IdWidth      = 29;
   localparam int DlcWidth     = 4;
   localparam int RunWidth     = 3;
   localparam int StuffRun     = 5;

   localparam logic [CrcWidth-1:0] CrcPoly = 15'h4599;

   localparam logic MODE_HEADER = 1'b0;
   localparam logic MODE_DATA   = 1'b1;

   localparam logic STATUS_OK         = 1'b0;
   localparam logic STATUS_UNEXPECTED = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEND,
      ST_STUFF
   } state_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_CLEAR,
      OP_PUSH,
      OP_STUFF
   } stuff_op_type;

   typedef struct packed {
      stuff_op_type op;
      logic         bit_value;
   } stuff_cmd_type;

   typedef struct packed {
      logic                need_stuff;
      logic                run_value;
      logic [CrcWidth-1:0] crc;
      logic [CrcWidth-1:0] crc_next;
   } stuff_status_type;

   typedef struct packed {
      logic                  load;
      logic                  shift;
      logic [FrameBits-1:0]  load_bits;
      logic [CountWidth-1:0] load_count;
   } shift_cmd_type;

   typedef struct packed {
      logic msb;
      logic last;
      logic empty;
   } shift_status_type;

   // left aligned header bits, sof first
   function automatic logic [FrameBits-1:0] header_bits(
      input logic [IdWidth-1:0]  id,
      input logic                ext,
      input logic                rtr,
      input logic [DlcWidth-1:0] dlc
   );
      logic [FrameBits-1:0] bits;
      if (ext) begin
         bits = {1'b0, id[28:18], 2'b11, id[17:0], rtr, 2'b00, dlc};
      end else begin
         bits = {1'b0, id[10:0], rtr, 2'b00, dlc, {(FrameBits - StdBits){1'b0}}};
      end
      return bits;
   endfunction

endpackage

// ----- rtl/can_fs_if.sv -----
// valid/ready channel interfaces for frame requests and line bit responses
interface can_fs_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [28:0] identifier;
   logic        extended_format;
   logic        remote_request;
   logic [3:0]  length_code;
   logic [7:0]  data_byte;

   modport source (
      output valid, mode, identifier, extended_format, remote_request, length_code,
             data_byte,
      input  ready
   );
   modport sink (
      input  valid, mode, identifier, extended_format, remote_request, length_code,
             data_byte,
      output ready
   );
endinterface

interface can_fs_rsp_if;
   logic        valid;
   logic        ready;
   logic        line_bit;
   logic        is_stuff_bit;
   logic        last_of_run;
   logic        frame_done;
   logic [14:0] crc_value;
   logic        status;

   modport source (
      output valid, line_bit, is_stuff_bit, last_of_run, frame_done, crc_value, status,
      input  ready
   );
   modport sink (
      input  valid, line_bit, is_stuff_bit, last_of_run, frame_done, crc_value, status,
      output ready
   );
endinterface

// ----- rtl/can_fs_shifter.sv -----
// frame bit source: loadable shift register with remaining bit count
module can_fs_shifter
   import can_fs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  shift_cmd_type    cmd,
   output shift_status_type status
);

   logic [FrameBits-1:0]  shift_ff;
   logic [FrameBits-1:0]  shift_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;

   always_comb begin
      shift_in = shift_ff;
      count_in = count_ff;
      if (cmd.load) begin
         shift_in = cmd.load_bits;
         count_in = cmd.load_count;
      end else if (cmd.shift) begin
         shift_in = {shift_ff[FrameBits-2:0], 1'b0};
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign status.msb   = shift_ff[FrameBits-1];
   assign status.last  = (count_ff == CountWidth'(1));
   assign status.empty = (count_ff == '0);

   property p_no_shift_when_empty;
      @(posedge clock) disable iff (reset)
         (cmd.shift && !cmd.load) |-> (count_ff != '0);
   endproperty
   a_no_shift_when_empty: assert property (p_no_shift_when_empty)
      else $error("shift requested with no bits left");

   property p_count_bound;
      @(posedge clock) disable iff (reset)
         count_ff <= CountWidth'(FrameBits);
   endproperty
   a_count_bound: assert property (p_count_bound)
      else $error("bit count beyond frame length");

   property p_shift_counts_down;
      @(posedge clock) disable iff (reset)
         (cmd.shift && !cmd.load) |=> (count_ff == $past(count_ff) - CountWidth'(1));
   endproperty
   a_shift_counts_down: assert property (p_shift_counts_down)
      else $error("bit count did not step down");

endmodule

// ----- rtl/can_fs_stuffer.sv -----
// shared stuffing and crc-15 unit, one line bit per command
module can_fs_stuffer
   import can_fs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  stuff_cmd_type    cmd,
   output stuff_status_type status
);

   logic                run_value_ff;
   logic                run_value_in;
   logic [RunWidth-1:0] run_length_ff;
   logic [RunWidth-1:0] run_length_in;
   logic [CrcWidth-1:0] crc_ff;
   logic [CrcWidth-1:0] crc_in;
   logic [CrcWidth-1:0] crc_step;
   logic [RunWidth-1:0] run_step;

   always_comb begin
      crc_step = {crc_ff[CrcWidth-2:0], 1'b0};
      if (crc_ff[CrcWidth-1] ^ cmd.bit_value) begin
         crc_step = crc_step ^ CrcPoly;
      end
      if (run_length_ff != '0 && cmd.bit_value == run_value_ff) begin
         run_step = run_length_ff + RunWidth'(1);
      end else begin
         run_step = RunWidth'(1);
      end
   end

   always_comb begin
      run_value_in  = run_value_ff;
      run_length_in = run_length_ff;
      crc_in        = crc_ff;
      case (cmd.op)
         OP_CLEAR: begin
            run_value_in  = 1'b0;
            run_length_in = '0;
            crc_in        = '0;
         end
         OP_PUSH: begin
            run_value_in  = cmd.bit_value;
            run_length_in = run_step;
            crc_in        = crc_step;
         end
         OP_STUFF: begin
            run_value_in  = ~run_value_ff;
            run_length_in = RunWidth'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_value_ff  <= 1'b0;
         run_length_ff <= '0;
         crc_ff        <= '0;
      end else begin
         run_value_ff  <= run_value_in;
         run_length_ff <= run_length_in;
         crc_ff        <= crc_in;
      end
   end

   assign status.need_stuff = (run_step >= RunWidth'(StuffRun));
   assign status.run_value  = run_value_ff;
   assign status.crc        = crc_ff;
   assign status.crc_next   = crc_step;

   property p_stuff_after_run;
      @(posedge clock) disable iff (reset)
         (cmd.op == OP_STUFF) |-> (run_length_ff == RunWidth'(StuffRun));
   endproperty
   a_stuff_after_run: assert property (p_stuff_after_run)
      else $error("stuff bit without a full run");

   property p_run_bound;
      @(posedge clock) disable iff (reset)
         run_length_ff <= RunWidth'(StuffRun);
   endproperty
   a_run_bound: assert property (p_run_bound)
      else $error("run longer than the stuffing limit");

   property p_crc_hold_on_stuff;
      @(posedge clock) disable iff (reset)
         (cmd.op == OP_STUFF) |=> (crc_ff == $past(crc_ff));
   endproperty
   a_crc_hold_on_stuff: assert property (p_crc_hold_on_stuff)
      else $error("crc changed on a stuff bit");

endmodule

// ----- rtl/can_frame_stuff_crc15.sv -----
// top level: classical can frame builder with bit stuffing and crc-15
// A header transaction produces SOF, identifier, control bits and DLC (19 line bits for
// a standard frame, 39 for an extended one) plus any stuff bits; each data byte
// transaction produces 8 to 10 line bits. One line bit leaves per cycle through the single
// stuffing/CRC unit, except while the response side stalls; accepting a transaction gives
// no line bit itself. Requests are taken only when the block is idle and its response
// register is free. A data byte with no open frame returns one response with status set.
// The CRC covers the unstuffed bits from SOF to the end of the data field and is reported
// with frame_done on the last line bit of the frame, which may be a stuff bit.
module can_frame_stuff_crc15
   import can_fs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   can_fs_req_if.sink          req_if,
   can_fs_rsp_if.source        rsp_if
);

   state_type            state_ff;
   state_type            state_in;
   logic [DlcWidth-1:0]  bytes_left_ff;
   logic [DlcWidth-1:0]  bytes_left_in;
   logic                 frame_open_ff;
   logic                 frame_open_in;
   logic                 done_ff;
   logic                 done_in;

   logic                 rsp_valid_ff;
   logic                 line_bit_ff;
   logic                 is_stuff_bit_ff;
   logic                 last_of_run_ff;
   logic                 frame_done_ff;
   logic [CrcWidth-1:0]  crc_value_ff;
   logic                 status_ff;

   logic                 rsp_load;
   logic                 line_bit_in;
   logic                 is_stuff_bit_in;
   logic                 last_of_run_in;
   logic                 frame_done_in;
   logic [CrcWidth-1:0]  crc_value_in;
   logic                 status_in;

   logic                 slot_free;
   logic                 req_accept;
   logic [DlcWidth-1:0]  dlc_bytes;

   shift_cmd_type        shift_cmd;
   shift_status_type     shift_status;
   stuff_cmd_type        stuff_cmd;
   stuff_status_type     stuff_status;

   can_fs_shifter u_shifter (
      .clock  (clock),
      .reset  (reset),
      .cmd    (shift_cmd),
      .status (shift_status)
   );

   can_fs_stuffer u_stuffer (
      .clock  (clock),
      .reset  (reset),
      .cmd    (stuff_cmd),
      .status (stuff_status)
   );

   assign slot_free     = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready  = (state_ff == ST_IDLE) && slot_free;
   assign req_accept    = req_if.valid && req_if.ready;
   assign dlc_bytes     = (req_if.length_code > DlcWidth'(MaxBytes)) ?
                          DlcWidth'(MaxBytes) : req_if.length_code;

   always_comb begin
      state_in        = state_ff;
      bytes_left_in   = bytes_left_ff;
      frame_open_in   = frame_open_ff;
      done_in         = done_ff;
      shift_cmd       = '0;
      stuff_cmd.op    = OP_HOLD;
      stuff_cmd.bit_value = shift_status.msb;
      rsp_load        = 1'b0;
      line_bit_in     = 1'b0;
      is_stuff_bit_in = 1'b0;
      last_of_run_in  = 1'b0;
      frame_done_in   = 1'b0;
      crc_value_in    = '0;
      status_in       = STATUS_OK;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_if.mode == MODE_HEADER) begin
                  shift_cmd.load      = 1'b1;
                  shift_cmd.load_bits = header_bits(req_if.identifier,
                                                    req_if.extended_format,
                                                    req_if.remote_request,
                                                    req_if.length_code);
                  shift_cmd.load_count = req_if.extended_format ?
                                         CountWidth'(FrameBits) : CountWidth'(StdBits);
                  stuff_cmd.op    = OP_CLEAR;
                  bytes_left_in   = req_if.remote_request ? '0 : dlc_bytes;
                  frame_open_in   = (bytes_left_in != '0);
                  done_in         = !frame_open_in;
                  state_in        = ST_SEND;
               end else if (frame_open_ff && bytes_left_ff != '0) begin
                  shift_cmd.load       = 1'b1;
                  shift_cmd.load_bits  = {req_if.data_byte, {(FrameBits - ByteBits){1'b0}}};
                  shift_cmd.load_count = CountWidth'(ByteBits);
                  bytes_left_in   = bytes_left_ff - DlcWidth'(1);
                  done_in         = (bytes_left_in == '0);
                  frame_open_in   = !done_in;
                  state_in        = ST_SEND;
               end else begin
                  rsp_load        = 1'b1;
                  last_of_run_in  = 1'b1;
                  status_in       = STATUS_UNEXPECTED;
               end
            end
         end
         ST_SEND: begin
            if (slot_free) begin
               stuff_cmd.op    = OP_PUSH;
               shift_cmd.shift = 1'b1;
               rsp_load        = 1'b1;
               line_bit_in     = shift_status.msb;
               last_of_run_in  = shift_status.last && !stuff_status.need_stuff;
               frame_done_in   = last_of_run_in && done_ff;
               crc_value_in    = frame_done_in ? stuff_status.crc_next : '0;
               if (stuff_status.need_stuff) begin
                  state_in = ST_STUFF;
               end else if (shift_status.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_STUFF: begin
            if (slot_free) begin
               stuff_cmd.op    = OP_STUFF;
               rsp_load        = 1'b1;
               line_bit_in     = ~stuff_status.run_value;
               is_stuff_bit_in = 1'b1;
               last_of_run_in  = shift_status.empty;
               frame_done_in   = last_of_run_in && done_ff;
               crc_value_in    = frame_done_in ? stuff_status.crc : '0;
               state_in        = shift_status.empty ? ST_IDLE : ST_SEND;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bytes_left_ff <= '0;
         frame_open_ff <= 1'b0;
         done_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bytes_left_ff <= bytes_left_in;
         frame_open_ff <= frame_open_in;
         done_ff       <= done_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         line_bit_ff     <= line_bit_in;
         is_stuff_bit_ff <= is_stuff_bit_in;
         last_of_run_ff  <= last_of_run_in;
         frame_done_ff   <= frame_done_in;
         crc_value_ff    <= crc_value_in;
         status_ff       <= status_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.line_bit     = line_bit_ff;
   assign rsp_if.is_stuff_bit = is_stuff_bit_ff;
   assign rsp_if.last_of_run  = last_of_run_ff;
   assign rsp_if.frame_done   = frame_done_ff;
   assign rsp_if.crc_value    = crc_value_ff;
   assign rsp_if.status       = status_ff;

   property p_send_has_bits;
      @(posedge clock) disable iff (reset)
         (state_ff == ST_SEND) |-> !shift_status.empty;
   endproperty
   a_send_has_bits: assert property (p_send_has_bits)
      else $error("send state with no bits left");

   property p_done_is_last;
      @(posedge clock) disable iff (reset)
         (rsp_valid_ff && frame_done_ff) |-> last_of_run_ff;
   endproperty
   a_done_is_last: assert property (p_done_is_last)
      else $error("frame done on a response that is not the last");

   property p_error_response_clean;
      @(posedge clock) disable iff (reset)
         (rsp_valid_ff && status_ff == STATUS_UNEXPECTED) |->
            (last_of_run_ff && !line_bit_ff && !frame_done_ff && crc_value_ff == '0);
   endproperty
   a_error_response_clean: assert property (p_error_response_clean)
      else $error("error response carries frame fields");

   property p_frame_state_consistent;
      @(posedge clock) disable iff (reset)
         frame_open_ff == (bytes_left_ff != '0);
   endproperty
   a_frame_state_consistent: assert property (p_frame_state_consistent)
      else $error("open frame flag disagrees with byte count");

endmodule
